// ===== src/ldct_pkg.sv =====
`default_nettype none

package ldct_pkg;

  // Counter and remainder widths
  localparam int COUNT_WIDTH = 16;
  localparam int DELAY_WIDTH = 24;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_IDX_W   = 2;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((DELAY_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS   = COUNT_WIDTH + DELAY_WIDTH;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [DELAY_WIDTH-1:0] FULL_RANGE  = DELAY_WIDTH'(1) << COUNT_WIDTH;
  localparam logic [DELAY_WIDTH-1:0] HALF_RANGE  = DELAY_WIDTH'(1) << (COUNT_WIDTH - 1);
  localparam logic [DELAY_WIDTH-1:0] SHORT_LIMIT = FULL_RANGE - DELAY_WIDTH'(256);

  localparam logic [CFG_WIDTH-1:0] IDLE_RESET = CFG_WIDTH'(65500);
  localparam logic [CFG_WIDTH-1:0] LEAD_RESET = CFG_WIDTH'(100);

  // Input item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_PERIOD = 2'd0,
    CFG_MIN_LEAD    = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic                   expired;
    logic [COUNT_WIDTH-1:0] compare_value;
    logic [DELAY_WIDTH-1:0] remaining_wait;
  } result_t;

endpackage

`default_nettype wire

// ===== src/long_delay_compare_timer_unit.sv =====
// Extended-range compare timer.
// Input channel (in_*): one request per item. in_tuser is the kind
// (0 = tick, 1 = load), in_tdata[23:0] is the delay used by a load.
// Output channel (out_*): one result per request. out_tuser is the expired
// flag, out_tdata holds compare_value then remaining_wait.
// Config channel (cfg_*): cfg_index 0 = idle_period, 1 = min_lead; other
// indexes are accepted and dropped. cfg_ready is always high; write only
// while no request is in flight.
// Each result is registered, in the output register or in the skid entry.
// Throughput: one request per cycle while in_tready is high; state update is
// 16/24-bit compares, 16-bit adds, 24-bit subtracts between the registers.
// Stall: an output register plus one skid entry. A request is still taken
// while a result waits; in_tready drops only when the skid entry is full.
// Reset (rst_n low, synchronous): count 0, compare 65500, remainder 0,
// idle_period 65500, min_lead 100, output and skid empty.
`default_nettype none

module long_delay_compare_timer_unit
  import ldct_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: [23:0] delay
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: [0] kind
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata: [15:0] compare_value, [39:16] remaining_wait
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: [0] expired
  output logic                       out_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_WIDTH-1:0]  cfg_data
);

  logic [CFG_WIDTH-1:0]   idle_r, lead_r;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0] cmp_r, cmp_nxt;
  logic [DELAY_WIDTH-1:0] extra_r, extra_nxt;
  logic                   expired_nxt;

  result_t out_r, skid_r, res_nxt;
  logic    out_valid_r, skid_valid_r;

  logic                   in_acc, out_take;
  logic [DELAY_WIDTH-1:0] delay;
  logic [COUNT_WIDTH-1:0] earliest;

  assign cfg_ready = 1'b1;
  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign out_take  = out_valid_r & out_tready;
  assign delay     = in_tdata[DELAY_WIDTH-1:0];
  assign earliest  = tick_r + COUNT_WIDTH'(lead_r);

  // Next state for one request
  always_comb begin
    tick_nxt    = tick_r;
    cmp_nxt     = cmp_r;
    extra_nxt   = extra_r;
    expired_nxt = 1'b0;
    if (in_tuser == KIND_TICK) begin
      if (tick_r == cmp_r) begin
        tick_nxt = '0;
        if (extra_r >= FULL_RANGE) begin
          // long remainder: work off a half-range chunk
          extra_nxt = extra_r - HALF_RANGE;
        end else if (extra_r != '0) begin
          // last short piece goes to the compare register
          cmp_nxt   = extra_r[COUNT_WIDTH-1:0];
          extra_nxt = '0;
        end else begin
          expired_nxt = 1'b1;
          cmp_nxt     = COUNT_WIDTH'(idle_r);
        end
      end else begin
        tick_nxt = tick_r + COUNT_WIDTH'(1);
      end
    end else begin
      if (delay < SHORT_LIMIT) begin
        extra_nxt = '0;
        if (delay < {{(DELAY_WIDTH-COUNT_WIDTH){1'b0}}, earliest}) begin
          cmp_nxt = earliest;
        end else begin
          cmp_nxt = delay[COUNT_WIDTH-1:0];
        end
      end else begin
        extra_nxt = delay - HALF_RANGE;
        cmp_nxt   = HALF_RANGE[COUNT_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    res_nxt.expired        = expired_nxt;
    res_nxt.compare_value  = cmp_nxt;
    res_nxt.remaining_wait = extra_nxt;
  end

  // Timer state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r  <= IDLE_RESET;
      lead_r  <= LEAD_RESET;
      tick_r  <= '0;
      cmp_r   <= COUNT_WIDTH'(IDLE_RESET);
      extra_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_IDLE_PERIOD: idle_r <= cfg_data;
          CFG_MIN_LEAD:    lead_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        tick_r  <= tick_nxt;
        cmp_r   <= cmp_nxt;
        extra_r <= extra_nxt;
      end
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_tready) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.expired;
  assign out_tdata  = OUT_DATA_W'({out_r.remaining_wait, out_r.compare_value});

endmodule

`default_nettype wire

// ===== src/ldct_checker.sv =====
`default_nettype none

module ldct_checker
  import ldct_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // back-pressure only while a result is waiting
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && $past(out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

  // an accepted request leaves out_tvalid high next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted request");

  // expiry only with an empty remainder
  a_expire_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_BITS-1:COUNT_WIDTH] == '0)
    else $error("expired with remainder left");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready && cfg_ready)
    else $error("output not empty after reset");

endmodule

bind long_delay_compare_timer_unit ldct_checker u_ldct_checker (.*);

`default_nettype wire
